### hw/rtl/line_framer_sum_checksum_core_macros.svh
// Assertion macros used by the line framer checker.
// Each macro expands to one labelled concurrent assertion, disabled in reset.
`ifndef LINE_FRAMER_SUM_CHECKSUM_CORE_MACROS_SVH
`define LINE_FRAMER_SUM_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication.
`define LFSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared constants, types and byte classifiers for the line framer.
// ----------------------------------------------------------------------------
package lfsc_pkg;

  localparam int LINE_CAPACITY = 512;
  localparam int COUNT_W       = $clog2(LINE_CAPACITY);
  localparam int LEN_W         = 9;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(LINE_CAPACITY - 1);

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MIN  = 8'h2D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [1:0] ST_GOOD   = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NOSTAR = 2'd2;

  // Per-byte control decoded in the top level
  typedef struct packed {
    logic clear;     // newline: restart the line
    logic store;     // byte stored in the line
    logic set_ovf;   // byte dropped on a full line
    logic zero_set;  // zero byte ends checked content
    logic checked;   // byte enters the running sum
    logic star;      // checked '*'
    logic feed;      // checked byte after a '*'
  } lfsc_ctl_t;

  // Line status reported back to the top level
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         total;
    logic [7:0]         saved;
    logic               marker;
    logic               zero_seen;
    logic               ovf;
    logic               full;
  } lfsc_line_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } lfsc_digit_t;

  function automatic lfsc_digit_t hex_digit(input logic [7:0] c);
    lfsc_digit_t d;
    d = '{valid: 1'b0, value: 4'd0};
    if (c inside {[8'h30:8'h39]}) begin
      d = '{valid: 1'b1, value: c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = '{valid: 1'b1, value: 4'(c[2:0] + 3'd1) + 4'd8};
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0B, 8'h0C};
  endfunction

endpackage

### hw/rtl/lfsc_line_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_line_track
// Stored length, running sum, saved sum at the last '*' and line flags.
// ----------------------------------------------------------------------------
module lfsc_line_track (
  input  logic               clk,
  input  logic               rst_n,
  input  lfsc_pkg::lfsc_ctl_t ctl,
  input  logic [7:0]         data,
  output lfsc_pkg::lfsc_line_t line
);
  import lfsc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         total_r, total_nxt;
  logic [7:0]         saved_r, saved_nxt;
  logic               marker_r, marker_nxt;
  logic               zero_r, zero_nxt;
  logic               ovf_r, ovf_nxt;

  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    saved_nxt  = saved_r;
    marker_nxt = marker_r;
    zero_nxt   = zero_r;
    ovf_nxt    = ovf_r;
    if (ctl.clear) begin
      count_nxt  = '0;
      total_nxt  = '0;
      saved_nxt  = '0;
      marker_nxt = 1'b0;
      zero_nxt   = 1'b0;
      ovf_nxt    = 1'b0;
    end else begin
      if (ctl.set_ovf)  ovf_nxt   = 1'b1;
      if (ctl.store)    count_nxt = count_r + COUNT_W'(1);
      if (ctl.zero_set) zero_nxt  = 1'b1;
      if (ctl.star) begin
        saved_nxt  = total_r;
        marker_nxt = 1'b1;
      end
      if (ctl.checked)  total_nxt = total_r + data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      total_r  <= '0;
      saved_r  <= '0;
      marker_r <= 1'b0;
      zero_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      saved_r  <= saved_nxt;
      marker_r <= marker_nxt;
      zero_r   <= zero_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign line = '{count: count_r, total: total_r, saved: saved_r, marker: marker_r,
                  zero_seen: zero_r, ovf: ovf_r, full: (count_r >= FULL_COUNT)};

endmodule

### hw/rtl/lfsc_hex_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_hex_field
// Parser for the signed hex field that follows the last '*'.
// ----------------------------------------------------------------------------
module lfsc_hex_field (
  input  logic               clk,
  input  logic               rst_n,
  input  lfsc_pkg::lfsc_ctl_t ctl,
  input  logic [7:0]         data,
  output logic [7:0]         value
);
  import lfsc_pkg::*;

  localparam logic [1:0] HX_SKIP   = 2'd0;
  localparam logic [1:0] HX_SIGN   = 2'd1;
  localparam logic [1:0] HX_DIGITS = 2'd2;
  localparam logic [1:0] HX_DONE   = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  accum_r, accum_nxt;
  logic        minus_r, minus_nxt;
  lfsc_digit_t dig;

  assign dig = hex_digit(data);

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    minus_nxt = minus_r;
    if (ctl.clear || ctl.star) begin
      phase_nxt = HX_SKIP;
      accum_nxt = '0;
      minus_nxt = 1'b0;
    end else if (ctl.feed) begin
      case (phase_r)
        HX_SKIP: begin
          if (is_space(data)) begin
            phase_nxt = HX_SKIP;
          end else if (data == CH_PLUS || data == CH_MIN) begin
            minus_nxt = (data == CH_MIN);
            phase_nxt = HX_SIGN;
          end else if (dig.valid) begin
            accum_nxt = {4'd0, dig.value};
            phase_nxt = HX_DIGITS;
          end else begin
            phase_nxt = HX_DONE;
          end
        end
        HX_SIGN, HX_DIGITS: begin
          if (dig.valid) begin
            accum_nxt = {accum_r[3:0], dig.value};
            phase_nxt = HX_DIGITS;
          end else begin
            phase_nxt = HX_DONE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= HX_SKIP;
      accum_r <= '0;
      minus_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      minus_r <= minus_nxt;
    end
  end

  // apply the sign mod 256
  assign value = minus_r ? (8'd0 - accum_r) : accum_r;

endmodule

### hw/rtl/line_framer_sum_checksum_core.sv
`timescale 1ns / 1ps
// Datapath: an accepted byte waits in the input register, then is applied to the line state;
//   a closing newline's result is loaded into the result register that drives the out_ channel.
// Throughput: one byte per cycle, limited only by the single-byte update of the line
//   registers; a waiting result stalls input only when the byte held closes a line.
// Reset: synchronous, active low; clears the line state, the byte stage and out_valid.
// ----------------------------------------------------------------------------
// line_framer_sum_checksum_core
// Newline framer with an additive 8-bit checksum checked against the hex field
// after the last '*'. One result transaction per closed non-empty line.
// ----------------------------------------------------------------------------
module line_framer_sum_checksum_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [7:0]               out_computed_sum,
  output logic [7:0]               out_received_sum,
  output logic [lfsc_pkg::LEN_W-1:0] out_line_length,
  output logic                     out_truncated
);
  import lfsc_pkg::*;

  // Input register: one byte waiting to be applied to the line state
  logic       s1_valid_r;
  logic [7:0] s1_data_r;

  // Result register
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [7:0]       comp_r;
  logic [7:0]       recv_r;
  logic [LEN_W-1:0] len_r;
  logic             trunc_r;

  lfsc_ctl_t  ctl;
  lfsc_line_t line;
  logic [7:0] hex_val;

  logic is_nl;
  logic is_cr;
  logic emits;
  logic s1_take;
  logic step;
  logic in_take;
  logic out_drain;
  logic live;

  // Classify the held byte
  assign is_nl = (s1_data_r == CH_LF);
  assign is_cr = (s1_data_r == CH_CR);
  assign emits = is_nl && (line.count != '0);

  // The held byte proceeds unless it would overwrite a result that is still stalled
  assign s1_take  = !(emits && out_valid_r && out_stall);
  assign step     = s1_valid_r && s1_take;
  assign in_stall = s1_valid_r && !s1_take;
  assign in_take  = in_valid && !in_stall;
  assign out_drain = out_valid_r && !out_stall;

  // Bytes past a zero byte are stored but kept out of the checksum
  assign live = !line.zero_seen;

  always_comb begin
    ctl.clear    = step && is_nl;
    ctl.store    = step && !is_nl && !is_cr && !line.full;
    ctl.set_ovf  = step && !is_nl && !is_cr && line.full;
    ctl.zero_set = ctl.store && live && (s1_data_r == CH_NUL);
    ctl.checked  = ctl.store && live && (s1_data_r != CH_NUL);
    ctl.star     = ctl.checked && (s1_data_r == CH_STAR);
    ctl.feed     = ctl.checked && (s1_data_r != CH_STAR) && line.marker;
  end

  lfsc_line_track u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .data  (s1_data_r),
    .line  (line)
  );

  lfsc_hex_field u_hex (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .data  (s1_data_r),
    .value (hex_val)
  );

  // Input stage: load on every accepted transaction, empty once the byte is applied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_rx_data;
    end
  end

  // Result stage: load on a closing newline, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_drain) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emits) begin
      len_r   <= LEN_W'(line.count);
      trunc_r <= line.ovf;
      if (line.marker) begin
        comp_r   <= line.saved;
        recv_r   <= hex_val;
        status_r <= (line.saved == hex_val) ? ST_GOOD : ST_BAD;
      end else begin
        // no star: report the whole checked sum, received field reads as zero
        comp_r   <= line.total;
        recv_r   <= 8'd0;
        status_r <= ST_NOSTAR;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_computed_sum = comp_r;
  assign out_received_sum = recv_r;
  assign out_line_length  = len_r;
  assign out_truncated    = trunc_r;

endmodule

### hw/rtl/lfsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsc_checker
// Port-level checks on the result channel of the line framer.
// ----------------------------------------------------------------------------
`include "line_framer_sum_checksum_core_macros.svh"

module lfsc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_status,
  input logic [7:0]               out_computed_sum,
  input logic [7:0]               out_received_sum,
  input logic [lfsc_pkg::LEN_W-1:0] out_line_length,
  input logic                     out_truncated
);
  import lfsc_pkg::*;

  `LFSC_ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid, (out_status == ST_GOOD || out_status == ST_BAD || out_status == ST_NOSTAR), "status code out of range")
  `LFSC_ASSERT_IMPLY(a_nostar_recv, clk, rst_n, out_valid && out_status == ST_NOSTAR, out_received_sum == 8'd0, "received sum not zero without star")
  `LFSC_ASSERT_IMPLY(a_verdict, clk, rst_n, out_valid && out_status != ST_NOSTAR, ((out_status == ST_GOOD) == (out_computed_sum == out_received_sum)), "verdict disagrees with sums")
  `LFSC_ASSERT_IMPLY(a_len_nonzero, clk, rst_n, out_valid, out_line_length != '0, "result for an empty line")
  `LFSC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_computed_sum) && $stable(out_received_sum) && $stable(out_line_length) && $stable(out_truncated), "stalled result changed")

endmodule

bind line_framer_sum_checksum_core lfsc_checker u_lfsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_computed_sum (out_computed_sum),
  .out_received_sum (out_received_sum),
  .out_line_length  (out_line_length),
  .out_truncated    (out_truncated)
);

### test/line_framer_sum_checksum_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_framer_sum_checksum_core_tb
// Self-checking bench for the newline framer with additive 8-bit checksum.
// Received bytes are pushed through the input channel and mirrored in a
// scoreboard that predicts one line report per closed non-empty line. Every
// report on the output channel is compared field by field, in order, while
// both sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module line_framer_sum_checksum_core_tb;
  import lfsc_pkg::*;

  // Characters the stimulus and the predictor need beyond the package set
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_X     = 8'h78;

  // Progress of the hex field parse after a '*'
  typedef enum logic [1:0] {
    HEX_SKIP,
    HEX_SIGN,
    HEX_DIGITS,
    HEX_DONE
  } hex_phase_e;

  // One line report as it appears on the out_ channel
  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       computed_sum;
    logic [7:0]       received_sum;
    logic [LEN_W-1:0] line_length;
    logic             truncated;
  } line_report_t;

  // --------------------------------------------------------------------------
  // Line scoreboard: tracks the line being assembled and holds the reports
  // still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class line_scoreboard;
    logic [LEN_W-1:0] stored_count;
    logic [7:0]       running_sum;
    logic [7:0]       sum_at_star;
    logic [7:0]       field_value;
    logic             star_seen;
    logic             nul_seen;
    logic             field_neg;
    logic             dropped;
    hex_phase_e       field_phase;
    line_report_t     owed_reports[$];
    int               failures;

    function new();
      failures = 0;
      clear_line();
    endfunction

    function void clear_line();
      stored_count = '0;
      running_sum  = '0;
      sum_at_star  = '0;
      field_value  = '0;
      star_seen    = 1'b0;
      nul_seen     = 1'b0;
      field_neg    = 1'b0;
      dropped      = 1'b0;
      field_phase  = HEX_SKIP;
    endfunction

    function void feed_field(logic [7:0] c);
      logic       is_digit;
      logic [3:0] nib;
      is_digit = 1'b1;
      nib      = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
        nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
        nib = 4'(c[3:0] + 4'd9);
      end else begin
        is_digit = 1'b0;
      end
      case (field_phase)
        HEX_SKIP: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            return;
          end
          if (c == CH_PLUS || c == CH_MIN) begin
            field_neg   = (c == CH_MIN);
            field_phase = HEX_SIGN;
          end else if (is_digit) begin
            field_value = {4'd0, nib};
            field_phase = HEX_DIGITS;
          end else begin
            field_phase = HEX_DONE;
          end
        end
        HEX_SIGN, HEX_DIGITS: begin
          if (is_digit) begin
            field_value = {field_value[3:0], nib};
            field_phase = HEX_DIGITS;
          end else begin
            field_phase = HEX_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    // Note one accepted input transaction
    function void note_byte(logic [7:0] c);
      line_report_t r;
      if (c == CH_LF) begin
        if (stored_count != 0) begin
          r.line_length = stored_count;
          r.truncated   = dropped;
          if (star_seen) begin
            r.received_sum = field_neg ? 8'd0 - field_value : field_value;
            r.computed_sum = sum_at_star;
            r.status       = (r.computed_sum == r.received_sum) ? ST_GOOD : ST_BAD;
          end else begin
            r.received_sum = '0;
            r.computed_sum = running_sum;
            r.status       = ST_NOSTAR;
          end
          owed_reports.push_back(r);
        end
        clear_line();
        return;
      end
      if (stored_count >= LEN_W'(LINE_CAPACITY - 1)) begin
        if (c != CH_CR) dropped = 1'b1;
        return;
      end
      if (c == CH_CR) return;
      stored_count++;
      if (nul_seen) return;
      if (c == CH_NUL) begin
        nul_seen = 1'b1;
        return;
      end
      if (c == CH_STAR) begin
        sum_at_star = running_sum;
        star_seen   = 1'b1;
        field_phase = HEX_SKIP;
        field_value = '0;
        field_neg   = 1'b0;
      end else if (star_seen) begin
        feed_field(c);
      end
      running_sum = running_sum + c;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    // Check one accepted output transaction against the oldest owed report
    function void check_report(line_report_t got);
      line_report_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual %h", $time, got);
        failures++;
        return;
      end
      want = owed_reports.pop_front();
      compare_field("status",       want.status,       got.status);
      compare_field("computed_sum", want.computed_sum, got.computed_sum);
      compare_field("received_sum", want.received_sum, got.received_sum);
      compare_field("line_length",  want.line_length,  got.line_length);
      compare_field("truncated",    want.truncated,    got.truncated);
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_rx_data = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [7:0]       out_computed_sum;
  logic [7:0]       out_received_sum;
  logic [LEN_W-1:0] out_line_length;
  logic             out_truncated;

  always #1 clk = ~clk;

  line_framer_sum_checksum_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_data       (in_rx_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_computed_sum (out_computed_sum),
    .out_received_sum (out_received_sum),
    .out_line_length  (out_line_length),
    .out_truncated    (out_truncated)
  );

  line_scoreboard sb = new();

  // Idle rates of the two sides, in percent, changed per phase
  int        idle_pct   = 0;
  int        stall_pct  = 0;
  int        byte_count = 0;
  logic [7:0] line_buf[$];

  // --------------------------------------------------------------------------
  // Output side: check each accepted report, then pick the next stall value.
  // Signals are sampled at the edge, before any update scheduled by it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_report('{status: out_status, computed_sum: out_computed_sum,
                        received_sum: out_received_sum, line_length: out_line_length,
                        truncated: out_truncated});
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Input side. Called just after a rising edge; returns just after the edge
  // that accepted the transaction, with in_valid still high so that a
  // back-to-back byte never drops valid within one time step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_data <= b;
    // hold the byte until a cycle without stall takes it
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    byte_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  function automatic logic [7:0] random_non_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // Hex digit character of either case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
  endfunction

  // Well-formed line: payload, '*', optional blanks and sign, hex field that
  // usually matches; a few surplus high digits exercise the mod-256 wrap.
  task automatic build_good_line();
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] val;
    int         sign_kind;
    int         ndig;
    line_buf.delete();
    sum = '0;
    repeat ($urandom_range(0, 30)) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == CH_CR || b == CH_STAR);
      line_buf.push_back(b);
      sum = sum + b;
    end
    line_buf.push_back(CH_STAR);
    repeat ($urandom_range(0, 2)) line_buf.push_back(random_blank());
    sign_kind = $urandom_range(2);
    if (sign_kind == 1) line_buf.push_back(CH_PLUS);
    if (sign_kind == 2) line_buf.push_back(CH_MIN);
    val = (sign_kind == 2) ? 8'd0 - sum : sum;
    // corrupt the field now and then
    if ($urandom_range(4) == 0) val = val ^ 8'($urandom_range(1, 255));
    ndig = $urandom_range(1, 4);
    if (val > 15 && ndig == 1) ndig = 2;
    for (int i = ndig - 1; i >= 0; i--) begin
      if (i == 0)      line_buf.push_back(hex_char(val[3:0]));
      else if (i == 1) line_buf.push_back(hex_char(val[7:4]));
      else             line_buf.push_back(hex_char(4'($urandom_range(15))));
    end
    if ($urandom_range(2) == 0) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endtask

  // Broken line: dense in stars, signs, blanks, digits, 'x', zero and CR
  task automatic build_broken_line();
    line_buf.delete();
    repeat ($urandom_range(0, 40)) begin
      case ($urandom_range(9))
        0:       line_buf.push_back(CH_STAR);
        1:       line_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MIN);
        2:       line_buf.push_back(random_blank());
        3:       line_buf.push_back(hex_char(4'($urandom_range(15))));
        4:       line_buf.push_back(CH_X);
        5:       line_buf.push_back(($urandom_range(3) == 0) ? CH_NUL : CH_CR);
        default: line_buf.push_back(random_non_lf());
      endcase
    end
    line_buf.push_back(CH_LF);
  endtask

  // Raw noise: any byte, newline included
  task automatic build_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(255)));
  endtask

  // Long line closed by CR LF; without CRs in the body, 511 bytes fill it exactly
  task automatic build_long_line(input int n, input bit with_cr);
    logic [7:0] b;
    line_buf.delete();
    repeat (n) begin
      do b = random_non_lf(); while (!with_cr && b == CH_CR);
      line_buf.push_back(b);
    end
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed lines, then four idling phases
  // --------------------------------------------------------------------------
  initial begin
    int start_count;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: matching field, bare star with CR, empty line, blanks and
    // a minus sign, zero byte hiding a star, 0x prefix, no star at all
    send_text("A*41\n");
    send_byte(CH_STAR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_text("B*");
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_text("-be\n");
    send_byte(CH_NUL);
    send_text("*1\n");
    send_text("q* \t0x71\n");
    send_byte(8'hFF);
    send_byte(CH_LF);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      start_count = byte_count;
      while (byte_count - start_count < 100) begin
        case ($urandom_range(99)) inside
          [0:69]:  build_good_line();
          [70:84]: build_broken_line();
          default: build_noise();
        endcase
        send_buf();
      end
      // overrun the line store once, and fill it exactly once
      if (ph == 1) begin
        build_long_line(520 + $urandom_range(80), 1'b1);
        send_buf();
      end
      if (ph == 3) begin
        build_long_line(LINE_CAPACITY - 1, 1'b0);
        send_buf();
      end
    end
    // close any line left open by noise so that its report is checked too
    send_byte(CH_LF);
    in_valid <= 1'b0;

    // drain the owed reports, then give the pipeline a few spare cycles
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
